>>> src/v3a_pkg.sv
// Shared types, constants and helpers for the three-component fixed-point vector ALU.
// Depends on nothing; every other file in src uses it by scoped names.
package v3a_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int TOL_W      = 31;
  localparam int PROD_W     = 2 * WORD_BITS;
  localparam int SAT_W      = 2 * WORD_BITS + 2;
  localparam int ROOT_W     = WORD_BITS;
  localparam int SS_W       = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int NUM_W      = WORD_BITS + FRAC_BITS;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = NUM_W;
  localparam int ADDR_W     = 3;

  localparam logic [3:0] FN_ADD   = 4'd0;
  localparam logic [3:0] FN_SUB   = 4'd1;
  localparam logic [3:0] FN_SCALE = 4'd2;
  localparam logic [3:0] FN_DIV   = 4'd3;
  localparam logic [3:0] FN_NEG   = 4'd4;
  localparam logic [3:0] FN_DOT   = 4'd5;
  localparam logic [3:0] FN_CROSS = 4'd6;
  localparam logic [3:0] FN_LEN   = 4'd7;
  localparam logic [3:0] FN_NORM  = 4'd8;
  localparam logic [3:0] FN_CMP   = 4'd9;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic REG_TOL = 1'b0;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [3:0] func;
    word_t      ax;
    word_t      ay;
    word_t      az;
    word_t      bx;
    word_t      by_comp;
    word_t      bz;
    word_t      scalar_in;
    logic       compare_req;
  } in_item_t;

  typedef struct packed {
    word_t      rx;
    word_t      ry;
    word_t      rz;
    word_t      scalar_out;
    logic       equal_flag;
    logic [1:0] status;
  } out_item_t;

  // Side data that rides along the root and divide chains with each item.
  typedef struct packed {
    logic [3:0]                 op;
    word_t                      rx;
    word_t                      ry;
    word_t                      rz;
    word_t                      sc;
    logic                       eq;
    logic                       sat;
    logic                       err;
    logic [2:0][WORD_BITS-1:0]  nmag;
    logic [2:0]                 nneg;
    logic [WORD_BITS-1:0]       smag;
    logic                       sneg;
  } ride_t;

  typedef struct packed {
    word_t v;
    logic  f;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
    sat_t r;
    logic signed [SAT_W-1:0] maxv;
    logic signed [SAT_W-1:0] minv;
    maxv = (SAT_W'(1) <<< (WORD_BITS - 1)) - SAT_W'(1);
    minv = -(SAT_W'(1) <<< (WORD_BITS - 1));
    if (v > maxv) begin
      r.v = maxv[WORD_BITS-1:0];
      r.f = 1'b1;
    end else if (v < minv) begin
      r.v = minv[WORD_BITS-1:0];
      r.f = 1'b1;
    end else begin
      r.v = v[WORD_BITS-1:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> src/v3a_sqrt_cell.sv
// One bit of the restoring square-root chain: two radicand bits in, one root bit out.
// Depends on v3a_pkg for widths and the ride_t side data.
module v3a_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [v3a_pkg::REM_W-1:0]   in_rem,
  input  logic [v3a_pkg::ROOT_W-1:0]  in_root,
  input  logic [v3a_pkg::SS_W-1:0]    in_rad,
  input  v3a_pkg::ride_t              in_ride,
  output logic                        out_valid,
  output logic [v3a_pkg::REM_W-1:0]   out_rem,
  output logic [v3a_pkg::ROOT_W-1:0]  out_root,
  output logic [v3a_pkg::SS_W-1:0]    out_rad,
  output v3a_pkg::ride_t              out_ride
);

  logic                        valid_r;
  logic [v3a_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [v3a_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [v3a_pkg::SS_W-1:0]    rad_r, rad_nxt;
  v3a_pkg::ride_t              ride_r;
  logic [v3a_pkg::REM_W-1:0]   rem_sh, trial;
  logic                        ge;

  always_comb begin
    rem_sh   = {in_rem[v3a_pkg::REM_W-3:0], in_rad[v3a_pkg::SS_W-1 -: 2]};
    trial    = {1'b0, in_root, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {in_root[v3a_pkg::ROOT_W-2:0], ge};
    rad_nxt  = {in_rad[v3a_pkg::SS_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      ride_r <= in_ride;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_rad   = rad_r;
  assign out_ride  = ride_r;

endmodule

>>> src/v3a_div_cell.sv
// One quotient bit of the restoring divider, three lanes sharing one divisor.
// Depends on v3a_pkg for widths and the ride_t side data.
module v3a_div_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [2:0][v3a_pkg::ROOT_W-1:0]  in_rem,
  input  logic [2:0][v3a_pkg::NUM_W-1:0]   in_quo,
  input  logic [2:0][v3a_pkg::NUM_W-1:0]   in_num,
  input  logic [v3a_pkg::ROOT_W-1:0]       in_dvs,
  input  v3a_pkg::ride_t                   in_ride,
  output logic                             out_valid,
  output logic [2:0][v3a_pkg::ROOT_W-1:0]  out_rem,
  output logic [2:0][v3a_pkg::NUM_W-1:0]   out_quo,
  output logic [2:0][v3a_pkg::NUM_W-1:0]   out_num,
  output logic [v3a_pkg::ROOT_W-1:0]       out_dvs,
  output v3a_pkg::ride_t                   out_ride
);

  logic                             valid_r;
  logic [2:0][v3a_pkg::ROOT_W-1:0]  rem_r, rem_nxt;
  logic [2:0][v3a_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [2:0][v3a_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [v3a_pkg::ROOT_W-1:0]       dvs_r;
  v3a_pkg::ride_t                   ride_r;
  logic [v3a_pkg::ROOT_W:0]         rs, diff;
  logic                             ge;

  always_comb begin
    rs   = '0;
    diff = '0;
    ge   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      rs         = {in_rem[k], in_num[k][v3a_pkg::NUM_W-1]};
      ge         = (rs >= {1'b0, in_dvs});
      diff       = rs - {1'b0, in_dvs};
      rem_nxt[k] = ge ? diff[v3a_pkg::ROOT_W-1:0] : rs[v3a_pkg::ROOT_W-1:0];
      quo_nxt[k] = {in_quo[k][v3a_pkg::NUM_W-2:0], ge};
      num_nxt[k] = {in_num[k][v3a_pkg::NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      num_r  <= num_nxt;
      dvs_r  <= in_dvs;
      ride_r <= in_ride;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_num   = num_r;
  assign out_dvs   = dvs_r;
  assign out_ride  = ride_r;

endmodule

>>> src/vec3_fixed_point_alu_top.sv
// Vector ALU top: input register, multiply stage, sum/saturate stage, 32-cell root chain,
// 48-cell divide chain, output register. Throughput is one item per cycle; the pipeline
// moves as one unit and stops only when the output register holds an untaken result and
// the last divide cell holds another.
// Reset (rst_n low, synchronous) empties every stage and sets compare_tolerance to 1.
// Depends on v3a_pkg, v3a_sqrt_cell and v3a_div_cell.
module vec3_fixed_point_alu_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  v3a_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output v3a_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [v3a_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int W  = v3a_pkg::WORD_BITS;
  localparam int F  = v3a_pkg::FRAC_BITS;
  localparam int SC = v3a_pkg::SQRT_CELLS;
  localparam int DC = v3a_pkg::DIV_CELLS;

  // ---------------------------------------------------------------- config
  logic [v3a_pkg::TOL_W-1:0] tol_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr[v3a_pkg::ADDR_W-1] == v3a_pkg::REG_TOL);
  assign cfg_prdata = (cfg_paddr[v3a_pkg::ADDR_W-1] == v3a_pkg::REG_TOL) ?
                      {1'b0, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= v3a_pkg::TOL_W'(1);
    end else if (cfg_wr) begin
      tol_r <= cfg_pwdata[v3a_pkg::TOL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- flow control
  // Every stage advances together on en. The output register parts the sides, so
  // the pipe keeps taking items while a result waits, as long as the last cell is empty.
  logic en;
  logic dv_last_v;
  logic out_valid_r;
  logic out_load;

  assign en       = ~out_valid_r | out_ready | ~dv_last_v;
  assign in_ready = en;
  assign out_load = en & dv_last_v;

  // ---------------------------------------------------------------- stage 1: capture
  logic               s1_v_r;
  v3a_pkg::in_item_t  s1_item_r;
  logic [3:0]         s1_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= in_data;
      s1_op_r   <= in_data.compare_req ? v3a_pkg::FN_CMP : in_data.func;
    end
  end

  // ---------------------------------------------------------------- stage 2: multiply
  // Six multipliers; operand pairs chosen by op. add/sub/negate and compare finish here.
  v3a_pkg::word_t         a [3];
  v3a_pkg::word_t         b [3];
  v3a_pkg::word_t         ma [6];
  v3a_pkg::word_t         mb [6];
  logic signed [W:0]      t33;
  logic [W:0]             dm;
  v3a_pkg::sat_t          sr;
  logic signed [v3a_pkg::PROD_W-1:0] p_nxt [6];
  v3a_pkg::word_t         lin_nxt [3];
  logic                   lin_sat_nxt, eq_nxt;
  logic [2:0][W-1:0]      nmag_nxt;
  logic [2:0]             nneg_nxt;
  logic [W-1:0]           smag_nxt;

  always_comb begin
    a[0] = s1_item_r.ax;
    a[1] = s1_item_r.ay;
    a[2] = s1_item_r.az;
    b[0] = s1_item_r.bx;
    b[1] = s1_item_r.by_comp;
    b[2] = s1_item_r.bz;
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (s1_op_r) inside
      v3a_pkg::FN_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = a[k];
          mb[k] = s1_item_r.scalar_in;
        end
      end
      v3a_pkg::FN_DOT: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = a[k];
          mb[k] = b[k];
        end
      end
      v3a_pkg::FN_CROSS: begin
        ma[0] = a[1]; mb[0] = b[2];
        ma[1] = a[2]; mb[1] = b[1];
        ma[2] = a[2]; mb[2] = b[0];
        ma[3] = a[0]; mb[3] = b[2];
        ma[4] = a[0]; mb[4] = b[1];
        ma[5] = a[1]; mb[5] = b[0];
      end
      v3a_pkg::FN_LEN, v3a_pkg::FN_NORM: begin
        for (int k = 0; k < 3; k++) begin
          ma[k] = a[k];
          mb[k] = a[k];
        end
      end
      default: ;
    endcase
    for (int k = 0; k < 6; k++) begin
      p_nxt[k] = ma[k] * mb[k];
    end

    lin_sat_nxt = 1'b0;
    eq_nxt      = 1'b1;
    t33         = '0;
    dm          = '0;
    sr          = '0;
    for (int k = 0; k < 3; k++) begin
      // element-wise add, subtract or negate, 33 bits wide then saturated
      case (s1_op_r)
        v3a_pkg::FN_ADD: t33 = {a[k][W-1], a[k]} + {b[k][W-1], b[k]};
        v3a_pkg::FN_SUB: t33 = {a[k][W-1], a[k]} - {b[k][W-1], b[k]};
        default:         t33 = -{a[k][W-1], a[k]};
      endcase
      sr          = v3a_pkg::sat_word(v3a_pkg::SAT_W'(t33));
      lin_nxt[k]  = sr.v;
      lin_sat_nxt = lin_sat_nxt | sr.f;
      // tolerance compare on the exact difference
      t33    = {a[k][W-1], a[k]} - {b[k][W-1], b[k]};
      dm     = t33[W] ? (W+1)'(0) - t33 : t33;
      eq_nxt = eq_nxt & (dm < {2'b00, tol_r});
      nneg_nxt[k] = a[k][W-1];
      nmag_nxt[k] = a[k][W-1] ? (W'(0) - a[k]) : a[k];
    end
    smag_nxt = s1_item_r.scalar_in[W-1] ? (W'(0) - s1_item_r.scalar_in) :
                                          s1_item_r.scalar_in;
  end

  logic                              s2_v_r;
  logic [3:0]                        s2_op_r;
  logic signed [v3a_pkg::PROD_W-1:0] s2_p_r [6];
  v3a_pkg::word_t                    s2_lin_r [3];
  logic                              s2_lin_sat_r, s2_eq_r, s2_sneg_r;
  logic [2:0][W-1:0]                 s2_nmag_r;
  logic [2:0]                        s2_nneg_r;
  logic [W-1:0]                      s2_smag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r      <= s1_op_r;
      s2_p_r       <= p_nxt;
      s2_lin_r     <= lin_nxt;
      s2_lin_sat_r <= lin_sat_nxt;
      s2_eq_r      <= eq_nxt;
      s2_nmag_r    <= nmag_nxt;
      s2_nneg_r    <= nneg_nxt;
      s2_smag_r    <= smag_nxt;
      s2_sneg_r    <= s1_item_r.scalar_in[W-1];
    end
  end

  // ---------------------------------------------------------------- stage 3: sums
  // Product sums shifted right by FRAC_BITS (floor), then saturated. Unknown ops stay zero.
  logic signed [v3a_pkg::SAT_W-1:0] ps [6];
  logic signed [v3a_pkg::SAT_W-1:0] acc;
  v3a_pkg::sat_t                    s0, s1, s2;
  v3a_pkg::ride_t                   ride3_nxt;
  logic [v3a_pkg::SS_W-1:0]         ss_nxt;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ps[k] = v3a_pkg::SAT_W'(s2_p_r[k]);
    end
    ride3_nxt      = '0;
    ride3_nxt.op   = s2_op_r;
    ride3_nxt.nmag = s2_nmag_r;
    ride3_nxt.nneg = s2_nneg_r;
    ride3_nxt.smag = s2_smag_r;
    ride3_nxt.sneg = s2_sneg_r;
    acc = '0;
    s0  = '0;
    s1  = '0;
    s2  = '0;
    case (s2_op_r) inside
      v3a_pkg::FN_ADD, v3a_pkg::FN_SUB, v3a_pkg::FN_NEG: begin
        ride3_nxt.rx  = s2_lin_r[0];
        ride3_nxt.ry  = s2_lin_r[1];
        ride3_nxt.rz  = s2_lin_r[2];
        ride3_nxt.sat = s2_lin_sat_r;
      end
      v3a_pkg::FN_SCALE: begin
        s0 = v3a_pkg::sat_word(ps[0] >>> F);
        s1 = v3a_pkg::sat_word(ps[1] >>> F);
        s2 = v3a_pkg::sat_word(ps[2] >>> F);
        ride3_nxt.rx  = s0.v;
        ride3_nxt.ry  = s1.v;
        ride3_nxt.rz  = s2.v;
        ride3_nxt.sat = s0.f | s1.f | s2.f;
      end
      v3a_pkg::FN_DOT: begin
        acc = ps[0] + ps[1] + ps[2];
        s0  = v3a_pkg::sat_word(acc >>> F);
        ride3_nxt.sc  = s0.v;
        ride3_nxt.sat = s0.f;
      end
      v3a_pkg::FN_CROSS: begin
        s0 = v3a_pkg::sat_word((ps[0] - ps[1]) >>> F);
        s1 = v3a_pkg::sat_word((ps[2] - ps[3]) >>> F);
        s2 = v3a_pkg::sat_word((ps[4] - ps[5]) >>> F);
        ride3_nxt.rx  = s0.v;
        ride3_nxt.ry  = s1.v;
        ride3_nxt.rz  = s2.v;
        ride3_nxt.sat = s0.f | s1.f | s2.f;
      end
      v3a_pkg::FN_CMP: ride3_nxt.eq = s2_eq_r;
      default: ;
    endcase
    // squares are never negative, so the unsigned sum of three is exact in 64 bits
    ss_nxt = $unsigned(s2_p_r[0]) + $unsigned(s2_p_r[1]) + $unsigned(s2_p_r[2]);
  end

  logic                      s3_v_r;
  v3a_pkg::ride_t            s3_ride_r;
  logic [v3a_pkg::SS_W-1:0]  s3_ss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ride_r <= ride3_nxt;
      s3_ss_r   <= ss_nxt;
    end
  end

  // ---------------------------------------------------------------- square-root chain
  // One root bit per cell; every item passes through, whatever its op.
  logic                         sq_v    [SC+1];
  logic [v3a_pkg::REM_W-1:0]    sq_rem  [SC+1];
  logic [v3a_pkg::ROOT_W-1:0]   sq_root [SC+1];
  logic [v3a_pkg::SS_W-1:0]     sq_rad  [SC+1];
  v3a_pkg::ride_t               sq_ride [SC+1];

  assign sq_v[0]    = s3_v_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = s3_ss_r;
  assign sq_ride[0] = s3_ride_r;

  for (genvar g = 0; g < SC; g++) begin : g_sqrt
    v3a_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[g]),
      .in_rem    (sq_rem[g]),
      .in_root   (sq_root[g]),
      .in_rad    (sq_rad[g]),
      .in_ride   (sq_ride[g]),
      .out_valid (sq_v[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_root  (sq_root[g+1]),
      .out_rad   (sq_rad[g+1]),
      .out_ride  (sq_ride[g+1])
    );
  end

  // Divisor pick: |scalar| for divide, the floor length for normalize.
  v3a_pkg::ride_t              ride_d;
  logic [v3a_pkg::ROOT_W-1:0]  dvs0;
  v3a_pkg::sat_t               len_s;

  always_comb begin
    ride_d = sq_ride[SC];
    dvs0   = (ride_d.op == v3a_pkg::FN_DIV) ? ride_d.smag : sq_root[SC];
    len_s  = v3a_pkg::sat_word(v3a_pkg::SAT_W'({1'b0, sq_root[SC]}));
    if (ride_d.op == v3a_pkg::FN_LEN) begin
      ride_d.sc  = len_s.v;
      ride_d.sat = len_s.f;
    end
    ride_d.err = ((ride_d.op == v3a_pkg::FN_DIV) || (ride_d.op == v3a_pkg::FN_NORM)) &&
                 (dvs0 == '0);
  end

  // ---------------------------------------------------------------- divide chain
  logic                              dv_v    [DC+1];
  logic [2:0][v3a_pkg::ROOT_W-1:0]   dv_rem  [DC+1];
  logic [2:0][v3a_pkg::NUM_W-1:0]    dv_quo  [DC+1];
  logic [2:0][v3a_pkg::NUM_W-1:0]    dv_num  [DC+1];
  logic [v3a_pkg::ROOT_W-1:0]        dv_dvs  [DC+1];
  v3a_pkg::ride_t                    dv_ride [DC+1];

  assign dv_v[0]    = sq_v[SC];
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_dvs[0]  = dvs0;
  assign dv_ride[0] = ride_d;

  for (genvar k = 0; k < 3; k++) begin : g_num
    assign dv_num[0][k] = {ride_d.nmag[k], F'(0)};
  end

  for (genvar g = 0; g < DC; g++) begin : g_div
    v3a_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[g]),
      .in_rem    (dv_rem[g]),
      .in_quo    (dv_quo[g]),
      .in_num    (dv_num[g]),
      .in_dvs    (dv_dvs[g]),
      .in_ride   (dv_ride[g]),
      .out_valid (dv_v[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_quo   (dv_quo[g+1]),
      .out_num   (dv_num[g+1]),
      .out_dvs   (dv_dvs[g+1]),
      .out_ride  (dv_ride[g+1])
    );
  end

  assign dv_last_v = dv_v[DC];

  // ---------------------------------------------------------------- result assembly
  // Quotients are truncated toward zero; sign applied, then saturated to the word.
  v3a_pkg::ride_t        rf;
  v3a_pkg::out_item_t    out_nxt;
  v3a_pkg::word_t        qv [3];
  logic [v3a_pkg::NUM_W-1:0] q;
  logic                  qneg, qsat;
  logic [v3a_pkg::NUM_W-1:0] lim_pos, lim_neg;

  always_comb begin
    rf      = dv_ride[DC];
    lim_pos = (v3a_pkg::NUM_W'(1) << (W - 1)) - v3a_pkg::NUM_W'(1);
    lim_neg = v3a_pkg::NUM_W'(1) << (W - 1);
    qsat    = 1'b0;
    q       = '0;
    qneg    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      q    = dv_quo[DC][k];
      qneg = rf.nneg[k] ^ ((rf.op == v3a_pkg::FN_DIV) & rf.sneg);
      if (!qneg && (q > lim_pos)) begin
        qv[k] = lim_pos[W-1:0];
        qsat  = 1'b1;
      end else if (qneg && (q > lim_neg)) begin
        qv[k] = lim_neg[W-1:0];
        qsat  = 1'b1;
      end else if (qneg) begin
        qv[k] = W'(0) - q[W-1:0];
      end else begin
        qv[k] = q[W-1:0];
      end
    end

    out_nxt.rx         = rf.rx;
    out_nxt.ry         = rf.ry;
    out_nxt.rz         = rf.rz;
    out_nxt.scalar_out = rf.sc;
    out_nxt.equal_flag = rf.eq;
    out_nxt.status     = rf.sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
    if ((rf.op == v3a_pkg::FN_DIV) || (rf.op == v3a_pkg::FN_NORM)) begin
      if (rf.err) begin
        out_nxt.rx     = '0;
        out_nxt.ry     = '0;
        out_nxt.rz     = '0;
        out_nxt.status = v3a_pkg::ST_ERR;
      end else begin
        out_nxt.rx     = qv[0];
        out_nxt.ry     = qv[1];
        out_nxt.rz     = qv[2];
        out_nxt.status = qsat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  v3a_pkg::out_item_t out_data_r;
  logic               out_valid_nxt;

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
